@@ rtl/core/feba_pkg.sv @@
// Shared types, constants and helpers of the free extent block allocator.
`default_nettype none
package feba_pkg;

   localparam int MAX_FREE = 64;
   localparam int IDX_W    = $clog2(MAX_FREE);
   localparam int CNT_W    = $clog2(MAX_FREE + 1);

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_AVAIL = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TABLE     = 2'd3;

   localparam logic       OP_CLAIM = 1'b0;
   localparam logic       OP_ALLOC = 1'b1;

   localparam logic [4:0] SHIFT_RESET = 5'd11;

   typedef struct packed {
      logic        opcode;
      logic [31:0] start_block;
      logic [31:0] length_bytes;
      logic        contiguous;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] location;
      logic [31:0] granted_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] blocks;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_type;

   function automatic logic [31:0] to_bytes_sat(input logic [31:0] blocks,
                                                input logic [4:0] shift);
      logic [62:0] wide;
      wide = {31'd0, blocks} << shift;
      if (|wide[62:32]) begin
         return 32'hffffffff;
      end
      return wide[31:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/feba_table.sv @@
// Free extent table memory: one write port, one registered read port.
`default_nettype none
module feba_table (
   input  wire logic                clock,
   input  wire feba_pkg::wr_type    wr,
   input  wire feba_pkg::rd_type    rd,
   output feba_pkg::entry_type      rd_data
);
   import feba_pkg::*;

   entry_type mem [MAX_FREE];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/free_extent_block_allocator.sv @@
// Top level of the free extent block allocator: request sequencer and result register.
// A request reads each free table entry it examines through the table's single
// read port, one entry at a time, and moves entries one at a time when an
// entry is inserted or removed. An allocate whose tentative
// claim fails restarts the claim scan, so the worst case grows with the
// square of the table fill (up to MAX_FREE entries). A new request is taken
// while an earlier result still waits on the result register.
`default_nettype none
module free_extent_block_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire feba_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output feba_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [4:0]        csr_data
);
   import feba_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_AL_RD    = 12'b000000000010,
      S_AL_CHK   = 12'b000000000100,
      S_FB       = 12'b000000001000,
      S_CL_START = 12'b000000010000,
      S_CL_RD    = 12'b000000100000,
      S_CL_CHK   = 12'b000001000000,
      S_SH_RD    = 12'b000010000000,
      S_SH_WR    = 12'b000100000000,
      S_PC_HI    = 12'b001000000000,
      S_PC_LO    = 12'b010000000000,
      S_FIN      = 12'b100000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  shift_ff, shift_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0] tail_ff, tail_in;
   logic [31:0] minb_ff, minb_in;
   logic [31:0] lbytes_ff, lbytes_in;
   logic        contig_ff, contig_in;
   logic [31:0] len_ff, len_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic        down_ff, down_in;
   logic [31:0] coff_ff, coff_in, clen_ff, clen_in;
   logic        resume_ff, resume_in;
   logic [31:0] loc_ff, loc_in, gb_ff, gb_in;
   logic        sat_ff, sat_in;
   logic [1:0]  status_ff, status_in;
   entry_type   hi_ff, hi_in, lo_ff, lo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   wr_type      wr;
   rd_type      rd;
   entry_type   rdata;

   logic [32:0] len_sum;
   logic [32:0] cend;
   logic [32:0] ce;
   logic [31:0] room;
   logic [31:0] pos;
   logic        table_full;

   feba_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rdata)
   );

   assign len_sum    = {1'b0, req_data.length_bytes} + (33'd1 << shift_ff) - 33'd1;
   assign cend       = {1'b0, coff_ff} + {1'b0, clen_ff};
   assign ce         = {1'b0, rdata.start} + {1'b0, rdata.blocks};
   assign room       = (minb_ff > tail_ff) ? ~minb_ff : ~tail_ff;
   assign pos        = (minb_ff > tail_ff) ? minb_ff : tail_ff;
   assign table_full = count_ff >= CNT_W'(MAX_FREE);

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      tail_in      = tail_ff;
      minb_in      = minb_ff;
      lbytes_in    = lbytes_ff;
      contig_in    = contig_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      down_in      = down_ff;
      coff_in      = coff_ff;
      clen_in      = clen_ff;
      resume_in    = resume_ff;
      loc_in       = loc_ff;
      gb_in        = gb_ff;
      sat_in       = sat_ff;
      status_in    = status_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr           = '0;
      rd           = '0;

      if (csr_valid) begin
         shift_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               minb_in   = req_data.start_block;
               lbytes_in = req_data.length_bytes;
               contig_in = req_data.contiguous;
               len_in    = 32'(len_sum >> shift_ff);
               loc_in    = req_data.start_block;
               sat_in    = 1'b0;
               if (req_data.opcode == OP_CLAIM) begin
                  coff_in   = req_data.start_block;
                  clen_in   = 32'(len_sum >> shift_ff);
                  resume_in = 1'b0;
                  state_in  = S_CL_START;
               end else begin
                  i_in     = '0;
                  state_in = S_AL_RD;
               end
            end
         end
         S_AL_RD: begin
            if (i_ff >= count_ff) begin
               state_in = S_FB;
            end else begin
               rd.en    = 1'b1;
               rd.addr  = i_ff[IDX_W-1:0];
               state_in = S_AL_CHK;
            end
         end
         S_AL_CHK: begin
            i_in     = i_ff + CNT_W'(1);
            state_in = S_AL_RD;
            if (rdata.start < minb_ff) begin
               if ({1'b0, minb_ff} < ce) begin
                  if (len_ff <= 32'(ce - {1'b0, minb_ff})) begin
                     coff_in   = minb_ff;
                     clen_in   = len_ff;
                     loc_in    = minb_ff;
                     sat_in    = 1'b0;
                     resume_in = 1'b1;
                     i_in      = i_ff;
                     state_in  = S_CL_START;
                  end else if (!contig_ff) begin
                     coff_in   = minb_ff;
                     clen_in   = 32'(ce - {1'b0, minb_ff});
                     gb_in     = 32'(ce - {1'b0, minb_ff});
                     loc_in    = minb_ff;
                     sat_in    = 1'b1;
                     resume_in = 1'b1;
                     i_in      = i_ff;
                     state_in  = S_CL_START;
                  end
               end
            end else if (len_ff <= rdata.blocks) begin
               loc_in    = rdata.start;
               sat_in    = 1'b0;
               status_in = ST_OK;
               if (len_ff != rdata.blocks) begin
                  wr.en       = 1'b1;
                  wr.addr     = i_ff[IDX_W-1:0];
                  wr.data     = '{start: rdata.start + len_ff, blocks: rdata.blocks - len_ff};
                  state_in    = S_FIN;
               end else begin
                  k_in     = i_ff;
                  down_in  = 1'b1;
                  state_in = S_SH_RD;
               end
            end else if (!contig_ff) begin
               loc_in    = rdata.start;
               gb_in     = rdata.blocks;
               sat_in    = 1'b1;
               status_in = ST_OK;
               k_in      = i_ff;
               down_in   = 1'b1;
               state_in  = S_SH_RD;
            end
         end
         S_FB: begin
            resume_in = 1'b0;
            loc_in    = pos;
            coff_in   = pos;
            if (tail_ff == 32'hffffffff) begin
               status_in = ST_FULL;
               state_in  = S_FIN;
            end else if (len_ff > room) begin
               if (contig_ff) begin
                  status_in = ST_FULL;
                  state_in  = S_FIN;
               end else begin
                  clen_in  = room;
                  gb_in    = room;
                  sat_in   = 1'b1;
                  state_in = S_CL_START;
               end
            end else begin
               clen_in  = len_ff;
               sat_in   = 1'b0;
               state_in = S_CL_START;
            end
         end
         S_CL_START: begin
            if (coff_ff >= tail_ff) begin
               if (cend[32]) begin
                  status_in = ST_FULL;
               end else if (coff_ff > tail_ff && table_full) begin
                  status_in = ST_TABLE;
               end else begin
                  if (coff_ff > tail_ff) begin
                     wr.en    = 1'b1;
                     wr.addr  = count_ff[IDX_W-1:0];
                     wr.data  = '{start: tail_ff, blocks: coff_ff - tail_ff};
                     count_in = count_ff + CNT_W'(1);
                  end
                  tail_in   = cend[31:0];
                  status_in = ST_OK;
               end
               if (status_in != ST_OK && resume_ff) begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = S_AL_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               j_in     = '0;
               state_in = S_CL_RD;
            end
         end
         S_CL_RD: begin
            if (j_ff >= count_ff) begin
               status_in = ST_NOT_AVAIL;
               if (resume_ff) begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = S_AL_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               rd.en    = 1'b1;
               rd.addr  = j_ff[IDX_W-1:0];
               state_in = S_CL_CHK;
            end
         end
         S_CL_CHK: begin
            if (rdata.start <= coff_ff && cend <= ce) begin
               status_in = ST_OK;
               state_in  = S_FIN;
               if (rdata.start < coff_ff && cend < ce) begin
                  if (table_full) begin
                     status_in = ST_TABLE;
                     if (resume_ff) begin
                        i_in     = i_ff + CNT_W'(1);
                        state_in = S_AL_RD;
                     end
                  end else begin
                     hi_in    = '{start: cend[31:0], blocks: 32'(ce - cend)};
                     lo_in    = '{start: rdata.start, blocks: coff_ff - rdata.start};
                     k_in     = count_ff;
                     down_in  = 1'b0;
                     state_in = S_SH_RD;
                  end
               end else if (rdata.start < coff_ff) begin
                  wr.en   = 1'b1;
                  wr.addr = j_ff[IDX_W-1:0];
                  wr.data = '{start: rdata.start, blocks: coff_ff - rdata.start};
               end else if (cend < ce) begin
                  wr.en   = 1'b1;
                  wr.addr = j_ff[IDX_W-1:0];
                  wr.data = '{start: cend[31:0], blocks: 32'(ce - cend)};
               end else begin
                  k_in     = j_ff;
                  down_in  = 1'b1;
                  state_in = S_SH_RD;
               end
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_CL_RD;
            end
         end
         S_SH_RD: begin
            if (down_ff) begin
               if (k_ff + CNT_W'(1) < count_ff) begin
                  rd.en    = 1'b1;
                  rd.addr  = IDX_W'(k_ff + CNT_W'(1));
                  state_in = S_SH_WR;
               end else begin
                  count_in  = count_ff - CNT_W'(1);
                  status_in = ST_OK;
                  state_in  = S_FIN;
               end
            end else begin
               if (k_ff > j_ff) begin
                  rd.en    = 1'b1;
                  rd.addr  = IDX_W'(k_ff - CNT_W'(1));
                  state_in = S_SH_WR;
               end else begin
                  state_in = S_PC_HI;
               end
            end
         end
         S_SH_WR: begin
            wr.en    = 1'b1;
            wr.addr  = k_ff[IDX_W-1:0];
            wr.data  = rdata;
            k_in     = down_ff ? k_ff + CNT_W'(1) : k_ff - CNT_W'(1);
            state_in = S_SH_RD;
         end
         S_PC_HI: begin
            wr.en    = 1'b1;
            wr.addr  = IDX_W'(j_ff + CNT_W'(1));
            wr.data  = hi_ff;
            state_in = S_PC_LO;
         end
         S_PC_LO: begin
            wr.en     = 1'b1;
            wr.addr   = j_ff[IDX_W-1:0];
            wr.data   = lo_ff;
            count_in  = count_ff + CNT_W'(1);
            status_in = ST_OK;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.location      = (status_ff == ST_OK) ? loc_ff : 32'd0;
               rsp_in.granted_bytes = (status_ff != ST_OK) ? 32'd0 :
                                      sat_ff ? to_bytes_sat(gb_ff, shift_ff) : lbytes_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= SHIFT_RESET;
         count_ff     <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      minb_ff   <= minb_in;
      lbytes_ff <= lbytes_in;
      contig_ff <= contig_in;
      len_ff    <= len_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      down_ff   <= down_in;
      coff_ff   <= coff_in;
      clen_ff   <= clen_in;
      resume_ff <= resume_in;
      loc_ff    <= loc_in;
      gb_ff     <= gb_in;
      sat_ff    <= sat_in;
      status_ff <= status_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FREE))
      else $error("free table count beyond depth");

   a_wr_in_fill: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ({1'b0, wr.addr} <= count_ff))
      else $error("table write beyond fill");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside finish");

endmodule
`default_nettype wire

@@ tb/free_extent_block_allocator_tb.sv @@
// Self-checking testbench of the free extent block allocator: directed and random requests.
`default_nettype none
module free_extent_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import feba_pkg::*;

   localparam int ITEMS_PER_PHASE = 240;
   localparam int CYCLE_LIMIT     = 40_000_000;
   localparam logic [31:0] ALL_ONES = 32'hffffffff;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;

   logic [31:0] ext_start [MAX_FREE];
   logic [31:0] ext_len   [MAX_FREE];
   int unsigned ext_cnt;
   logic [31:0] tail_m;
   logic [4:0]  shift_m;

   rsp_type     grant_q[$];
   int          fails = 0;
   longint      cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   free_extent_block_allocator dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] blocks_of(logic [31:0] b);
      return ({32'd0, b} + (64'd1 << shift_m) - 64'd1) >> shift_m;
   endfunction

   function automatic logic [31:0] bytes_of(logic [63:0] n);
      logic [63:0] w;
      w = n << shift_m;
      if (n > {32'd0, ALL_ONES} || w > {32'd0, ALL_ONES}) return ALL_ONES;
      return w[31:0];
   endfunction

   function automatic void ext_insert(int unsigned pos, logic [31:0] s, logic [31:0] n);
      for (int unsigned k = ext_cnt; k > pos; k--) begin
         ext_start[k] = ext_start[k-1];
         ext_len[k]   = ext_len[k-1];
      end
      ext_start[pos] = s;
      ext_len[pos]   = n;
      ext_cnt++;
   endfunction

   function automatic void ext_delete(int unsigned pos);
      for (int unsigned k = pos; k + 1 < ext_cnt; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k]   = ext_len[k+1];
      end
      ext_cnt--;
   endfunction

   function automatic logic [1:0] take_extent(logic [31:0] off, logic [63:0] len);
      logic [63:0] fin, ce;
      bit          lo, hi;
      fin = {32'd0, off} + len;
      if (off >= tail_m) begin
         if (fin > {32'd0, ALL_ONES}) return ST_FULL;
         if (off > tail_m) begin
            if (ext_cnt >= MAX_FREE) return ST_TABLE;
            ext_insert(ext_cnt, tail_m, off - tail_m);
         end
         tail_m = fin[31:0];
         return ST_OK;
      end
      for (int unsigned i = 0; i < ext_cnt; i++) begin
         ce = {32'd0, ext_start[i]} + {32'd0, ext_len[i]};
         if (ext_start[i] <= off && fin <= ce) begin
            lo = ext_start[i] < off;
            hi = fin < ce;
            if (lo && hi) begin
               if (ext_cnt >= MAX_FREE) return ST_TABLE;
               ext_insert(i, ext_start[i], off - ext_start[i]);
               ext_start[i+1] = fin[31:0];
               ext_len[i+1]   = 32'(ce - fin);
            end else if (lo) begin
               ext_len[i] = off - ext_start[i];
            end else if (hi) begin
               ext_start[i] = fin[31:0];
               ext_len[i]   = 32'(ce - fin);
            end else begin
               ext_delete(i);
            end
            return ST_OK;
         end
      end
      return ST_NOT_AVAIL;
   endfunction

   function automatic rsp_type make_grant(logic [1:0] st, logic [31:0] loc, logic [31:0] nb);
      rsp_type g;
      g.status        = st;
      g.location      = (st == ST_OK) ? loc : 32'd0;
      g.granted_bytes = (st == ST_OK) ? nb : 32'd0;
      return g;
   endfunction

   function automatic rsp_type predict_grant(req_type r);
      logic [63:0] len, cl, avail, room;
      logic [31:0] cs, pos, minb;
      minb = r.start_block;
      len  = blocks_of(r.length_bytes);
      if (r.opcode == OP_CLAIM)
         return make_grant(take_extent(minb, len), minb, r.length_bytes);
      for (int unsigned i = 0; i < ext_cnt; i++) begin
         cs = ext_start[i];
         cl = {32'd0, ext_len[i]};
         if (cs < minb) begin
            if ({32'd0, minb} < {32'd0, cs} + cl) begin
               avail = cl - {32'd0, minb - cs};
               if (len <= avail) begin
                  if (take_extent(minb, len) == ST_OK)
                     return make_grant(ST_OK, minb, r.length_bytes);
               end else if (!r.contiguous) begin
                  if (take_extent(minb, avail) == ST_OK)
                     return make_grant(ST_OK, minb, bytes_of(avail));
               end
            end
         end else if (len <= cl) begin
            if (len != cl) begin
               ext_start[i] = 32'({32'd0, cs} + len);
               ext_len[i]   = 32'(cl - len);
            end else begin
               ext_delete(i);
            end
            return make_grant(ST_OK, cs, r.length_bytes);
         end else if (!r.contiguous) begin
            ext_delete(i);
            return make_grant(ST_OK, cs, bytes_of(cl));
         end
      end
      room = {32'd0, ALL_ONES - tail_m};
      if (room == 0) return make_grant(ST_FULL, 0, 0);
      if (minb > tail_m) room -= {32'd0, minb - tail_m};
      pos = (minb > tail_m) ? minb : tail_m;
      if (len > room) begin
         if (r.contiguous) return make_grant(ST_FULL, 0, 0);
         return make_grant(take_extent(pos, room), pos, bytes_of(room));
      end
      return make_grant(take_extent(pos, len), pos, r.length_bytes);
   endfunction

   task automatic send_word(req_type r, bit known, rsp_type e);
      rsp_type p;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_grant(r);
      grant_q.insert(grant_q.size(), known ? e : p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_shift(logic [4:0] v);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shift_m = v;
   endtask

   function automatic req_type random_word(bit noisy);
      req_type     r;
      logic [63:0] lb;
      int unsigned kind, i;
      r.opcode     = 1'($urandom_range(0, 1));
      r.contiguous = 1'($urandom_range(0, 1));
      lb = (64'($urandom_range(0, 6)) << shift_m);
      if ($urandom_range(0, 1)) lb += 64'($urandom) & ((64'd1 << shift_m) - 1);
      r.length_bytes = lb[31:0];
      kind = $urandom_range(0, 9);
      i = (ext_cnt > 0) ? $urandom_range(0, ext_cnt - 1) : 0;
      if (ext_cnt > 0 && kind < 5)
         r.start_block = ext_start[i] + $urandom_range(0, 3);
      else if (kind < 8)
         r.start_block = tail_m + $urandom_range(0, 3);
      else
         r.start_block = $urandom_range(0, 3);
      if (r.opcode == OP_CLAIM && kind >= 5 && kind < 8)
         r.start_block = tail_m + $urandom_range(1, 3);
      if (noisy && $urandom_range(0, 3) == 0) begin
         r.start_block  = $urandom;
         r.length_bytes = $urandom;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** free_extent_block_allocator: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      rsp_stall <= reset ? 1'b0 : (stall_mode == 0) ? 1'b0 :
                   (stall_mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grant_q.size() == 0) begin
            $error("unexpected word: status %0d", rsp_data.status);
            fails++;
         end else begin
            e = grant_q.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_data.status);
               fails++;
            end
            if (rsp_data.location !== e.location) begin
               $error("location: expected %h, actual %h", e.location, rsp_data.location);
               fails++;
            end
            if (rsp_data.granted_bytes !== e.granted_bytes) begin
               $error("granted_bytes: expected %h, actual %h",
                      e.granted_bytes, rsp_data.granted_bytes);
               fails++;
            end
         end
      end
   end

   initial begin
      vector_type  vec[$];
      logic [4:0]  shifts[7];
      int unsigned n;
      shifts  = '{5'd11, 5'd0, 5'd31, 5'd16, 5'd3, 5'd7, 5'd0};
      ext_cnt = 0;
      tail_m  = 0;
      shift_m = SHIFT_RESET;
      for (int k = 0; k < MAX_FREE; k++) begin
         ext_start[k] = '0;
         ext_len[k]   = '0;
      end
      vec.insert(vec.size(), '{'{OP_CLAIM, ALL_ONES, 32'd2048, 1'b1}, 1, '{ST_FULL, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, 32'd0, 32'd0, 1'b1}, 1, '{ST_OK, 0, 0}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd10, 32'd4096, 1'b0}, 1, '{ST_OK, 10, 4096}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd3, 32'd0, 1'b0}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd3, 32'd2048, 1'b1}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd5, 32'd100000, 1'b1}, 1,
                               '{ST_NOT_AVAIL, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, 32'd0, 32'd40960, 1'b0}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, 32'd1, 32'd1, 1'b1}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd20, 32'd1, 1'b0}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, 32'd0, 32'd3000, 1'b0}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, ALL_ONES, ALL_ONES, 1'b1}, 1, '{ST_FULL, 0, 0}});
      vec.insert(vec.size(), '{'{OP_ALLOC, 32'd0, ALL_ONES, 1'b1}, 0, '{0, 0, 0}});
      vec.insert(vec.size(), '{'{OP_CLAIM, 32'd0, ALL_ONES, 1'b0}, 0, '{0, 0, 0}});
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (vec[k]) send_word(vec[k].r, vec[k].known, vec[k].e);
      wait_drained();
      for (int p = 0; p < 7; p++) begin
         write_shift(shifts[p]);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_word(random_word(p == 6), 0, '{0, 0, 0});
            if (n == 120) wait_drained();
         end
      end
      wait_drained();
      repeat (50) @(posedge clock);
      if (fails == 0 && grant_q.size() == 0) begin
         $display("** free_extent_block_allocator: PASSED **");
      end else begin
         $display("** free_extent_block_allocator: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
